[design/ctok_pkg.sv]
// Shared constants and lookup functions for the C-like source tokenizer.
package ctok_pkg;

    // Default sizes.
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 12;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Token kinds.
    localparam logic [5:0] KIND_KEYWORD0 = 6'd33;
    localparam logic [5:0] KIND_IDENT    = 6'd44;
    localparam logic [5:0] KIND_NUMBER   = 6'd45;
    localparam logic [5:0] KIND_QUOTED   = 6'd46;
    localparam logic [5:0] KIND_EOF      = 6'd47;
    localparam logic [5:0] KIND_NONE     = 6'd63;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNFINISHED = 3'd1;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd2;
    localparam logic [2:0] ERR_CHAR_LEN   = 3'd3;
    localparam logic [2:0] ERR_FAULTY     = 3'd4;
    localparam logic [2:0] ERR_ESC_END    = 3'd5;

    // Kind of a two-character operator, or KIND_NONE.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        case ({a, b})
            "++":    k = 6'd0;
            "--":    k = 6'd1;
            "->":    k = 6'd2;
            "!=":    k = 6'd3;
            "==":    k = 6'd4;
            ">=":    k = 6'd5;
            "<=":    k = 6'd6;
            "<<":    k = 6'd7;
            ">>":    k = 6'd8;
            "&&":    k = 6'd9;
            "||":    k = 6'd10;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Kind of a one-character operator, or KIND_NONE.
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(":     k = 6'd11;
            ")":     k = 6'd12;
            "{":     k = 6'd13;
            "}":     k = 6'd14;
            "[":     k = 6'd15;
            "]":     k = 6'd16;
            ";":     k = 6'd17;
            ",":     k = 6'd18;
            "%":     k = 6'd19;
            "~":     k = 6'd20;
            "^":     k = 6'd21;
            ".":     k = 6'd22;
            "*":     k = 6'd23;
            "/":     k = 6'd24;
            "+":     k = 6'd25;
            "-":     k = 6'd26;
            "<":     k = 6'd27;
            ">":     k = 6'd28;
            "=":     k = 6'd29;
            "!":     k = 6'd30;
            "&":     k = 6'd31;
            "|":     k = 6'd32;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // True for a character that may open a two-character operator.
    function automatic logic may_pair(input logic [7:0] c);
        return c inside {"+", "-", "!", "=", ">", "<", "&", "|"};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c == "_") || (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {["0":"9"]}) || (c inside {["a":"f"]}) || (c inside {["A":"F"]});
    endfunction

    // Keyword lookup. The word's first character sits in the top byte;
    // n is the word length, or zero when it is too long for any keyword.
    function automatic logic [5:0] keyword_kind(input logic [63:0] w, input logic [3:0] n);
        logic [5:0] k;
        k = KIND_IDENT;
        case (n)
            4'd2: begin
                if (w[63:48] == "if") k = KIND_KEYWORD0 + 6'd2;
                if (w[63:48] == "do") k = KIND_KEYWORD0 + 6'd9;
            end
            4'd4: begin
                if (w[63:32] == "byte") k = KIND_KEYWORD0 + 6'd0;
                if (w[63:32] == "void") k = KIND_KEYWORD0 + 6'd3;
                if (w[63:32] == "else") k = KIND_KEYWORD0 + 6'd10;
            end
            4'd5: begin
                if (w[63:24] == "while") k = KIND_KEYWORD0 + 6'd1;
                if (w[63:24] == "break") k = KIND_KEYWORD0 + 6'd5;
            end
            4'd6: begin
                if (w[63:16] == "return") k = KIND_KEYWORD0 + 6'd4;
                if (w[63:16] == "struct") k = KIND_KEYWORD0 + 6'd8;
            end
            4'd7: begin
                if (w[63:8] == "typedef") k = KIND_KEYWORD0 + 6'd7;
            end
            4'd8: begin
                if (w == "continue") k = KIND_KEYWORD0 + 6'd6;
            end
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

[design/c_like_source_tokenizer.sv]
// Top level of the C-like source tokenizer: front end, bundle queue and back end.
//
// Takes one source byte per item, one item per cycle, and emits tokens (operators,
// keywords, identifiers, numbers, quoted literals, errors and a closing EOF token) as
// result items. A byte is processed in the cycle it is accepted; the tokens it
// completes (at most three) go as one bundle into a four-entry queue, and the back
// end sends one token per cycle from there while the receiver is ready, so input
// stalls only when the queue is full. After the EOF token or a fatal error the block
// still takes bytes but emits nothing until reset.
module c_like_source_tokenizer #(
    parameter int KEYWORD_CHARS = ctok_pkg::KEYWORD_CHARS_DEF,
    parameter int POSITION_BITS = ctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = ctok_pkg::LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    // start_line, start_column, token_length, error_code, zero fill
    output logic [((2*POSITION_BITS+LENGTH_BITS+3+7)/8)*8-1:0] m_tdata,
    output logic [6:0] m_tuser,   // token_kind, is_char_literal
    output logic       m_tlast    // last_token
);
    import ctok_pkg::*;

    localparam int TOK_W    = 6 + 1 + 2*POSITION_BITS + LENGTH_BITS + 3 + 1;
    localparam int BUNDLE_W = 2 + 3*TOK_W;
    localparam int DATA_W   = ((2*POSITION_BITS+LENGTH_BITS+3+7)/8)*8;
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);

    logic                in_fire;
    logic                push;
    logic [BUNDLE_W-1:0] push_data;
    logic                pop;
    logic                full;
    logic                not_empty;
    logic [BUNDLE_W-1:0] head_data;
    logic [CW-1:0]       level;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    ctok_front #(
        .KEYWORD_CHARS(KEYWORD_CHARS),
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .BUNDLE_W     (BUNDLE_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_ch    (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_data(push_data)
    );

    ctok_queue #(
        .WIDTH(BUNDLE_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .full     (full),
        .not_empty(not_empty),
        .head_data(head_data),
        .level    (level)
    );

    ctok_back #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .BUNDLE_W     (BUNDLE_W),
        .DATA_W       (DATA_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (not_empty),
        .q_data  (head_data),
        .q_pop   (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // The queue never overflows or underflows.
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (level <= CW'(QUEUE_DEPTH)) && !(pop && !not_empty) && !(push && full))
        else $error("bundle queue overflow or underflow");

    // Nothing follows the closing token.
    a_quiet_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && !not_empty)
        else $error("token emitted after the closing token");

    // Input is refused only when the queue is full.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> level == CW'(QUEUE_DEPTH))
        else $error("input stalled with room in the queue");

endmodule

[design/ctok_front.sv]
// Tokenizer front end: lexer state, one source byte per item, up to three tokens out.
module ctok_front #(
    parameter int KEYWORD_CHARS = 8,
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 12,
    parameter int BUNDLE_W      = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          in_ch,
    input  logic                in_last,
    output logic                push,
    output logic [BUNDLE_W-1:0] push_data
);
    import ctok_pkg::*;

    localparam int KI = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

    typedef struct packed {
        logic                     fin;
        logic [2:0]               err;
        logic [LENGTH_BITS-1:0]   len;
        logic [POSITION_BITS-1:0] col;
        logic [POSITION_BITS-1:0] line;
        logic                     isch;
        logic [5:0]               kind;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t [2:0] tok;
    } bundle_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_OPPEND = 8'b0000_0010,
        ST_IDENT  = 8'b0000_0100,
        ST_NUMBER = 8'b0000_1000,
        ST_QUOTE  = 8'b0001_0000,
        ST_ESC    = 8'b0010_0000,
        ST_ESCDEC = 8'b0100_0000,
        ST_ESCHEX = 8'b1000_0000
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);

    mode_t                     mode_reg, mode_next;
    logic [7:0]                pend_reg, pend_next;
    logic [POSITION_BITS-1:0]  line_reg, line_next;
    logic [POSITION_BITS-1:0]  col_reg, col_next;
    logic [POSITION_BITS-1:0]  tsc_reg, tsc_next;
    logic [POSITION_BITS-1:0]  qline_reg, qline_next;
    logic [LENGTH_BITS-1:0]    run_reg, run_next;
    logic [LENGTH_BITS-1:0]    lcc_reg, lcc_next;
    logic [2:0]                esc_reg, esc_next;
    logic                      qs_reg, qs_next;
    logic                      halted_reg, halted_next;
    logic [7:0]                wbuf_reg [KEYWORD_CHARS];
    logic [7:0]                wbuf_next [KEYWORD_CHARS];

    bundle_t    bundle;
    logic [63:0] kw_word;
    logic [3:0]  kw_len;

    function automatic logic [POSITION_BITS-1:0] inc_pos(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
        return (&v) ? v : v + LEN_ONE;
    endfunction

    function automatic tok_t make_tok(input logic [5:0] kind, input logic isch,
                                      input logic [POSITION_BITS-1:0] line,
                                      input logic [POSITION_BITS-1:0] col,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic [2:0] err, input logic fin);
        tok_t t;
        t.kind = kind;
        t.isch = isch;
        t.line = line;
        t.col  = col;
        t.len  = len;
        t.err  = err;
        t.fin  = fin;
        return t;
    endfunction

    // Stored word, first character in the top byte, for the keyword check.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            kw_word[63-8*j -: 8] = wbuf_reg[j];
        end
        kw_len = (run_reg <= LENGTH_BITS'(8)) ? run_reg[3:0] : 4'd0;
    end

    // Next lexer state and the tokens this byte completes.
    always_comb begin
        logic       go_idle;
        logic       go_quote;
        logic       dead;
        logic       word;
        logic       bad;
        logic [5:0] k;
        logic [7:0] qc;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tsc_next    = tsc_reg;
        qline_next  = qline_reg;
        run_next    = run_reg;
        lcc_next    = lcc_reg;
        esc_next    = esc_reg;
        qs_next     = qs_reg;
        halted_next = halted_reg;
        wbuf_next   = wbuf_reg;
        bundle      = '0;
        go_idle     = 1'b0;
        go_quote    = 1'b0;
        dead        = 1'b0;
        word        = 1'b0;
        bad         = 1'b0;
        k           = KIND_NONE;
        qc          = 8'd0;

        if (!halted_reg) begin
            case (mode_reg)
                ST_OPPEND: begin
                    mode_next = ST_IDLE;
                    k = pair_kind(pend_reg, in_ch);
                    if (k != KIND_NONE) begin
                        bundle.tok[bundle.cnt] = make_tok(k, 1'b0, line_reg, tsc_reg,
                                                          LENGTH_BITS'(2), ERR_NONE, 1'b0);
                        bundle.cnt = bundle.cnt + 2'd1;
                        col_next = inc_pos(inc_pos(col_reg));
                    end else begin
                        k = single_kind(pend_reg);
                        bundle.tok[bundle.cnt] = make_tok((k == KIND_NONE) ? 6'd0 : k, 1'b0,
                                                          line_reg, tsc_reg, LEN_ONE,
                                                          ERR_NONE, 1'b0);
                        bundle.cnt = bundle.cnt + 2'd1;
                        col_next = inc_pos(col_reg);
                        go_idle = 1'b1;
                    end
                end
                ST_IDENT, ST_NUMBER: begin
                    word = (mode_reg == ST_IDENT);
                    if (word ? is_letter(in_ch) : is_digit(in_ch)) begin
                        if (word && run_reg < LENGTH_BITS'(KEYWORD_CHARS)) begin
                            wbuf_next[run_reg[KI-1:0]] = in_ch;
                        end
                        run_next = inc_len(run_reg);
                        col_next = inc_pos(col_reg);
                        if (in_last) begin
                            bundle.tok[bundle.cnt] = make_tok(word ? KIND_IDENT : KIND_NUMBER,
                                                              1'b0, line_reg, col_next, run_next,
                                                              ERR_UNFINISHED, 1'b1);
                            bundle.cnt = bundle.cnt + 2'd1;
                            halted_next = 1'b1;
                            mode_next = ST_IDLE;
                            dead = 1'b1;
                        end
                    end else begin
                        bundle.tok[bundle.cnt] = make_tok(word ? keyword_kind(kw_word, kw_len)
                                                               : KIND_NUMBER,
                                                          1'b0, line_reg, tsc_reg, run_reg,
                                                          ERR_NONE, 1'b0);
                        bundle.cnt = bundle.cnt + 2'd1;
                        mode_next = ST_IDLE;
                        go_idle = 1'b1;
                    end
                end
                ST_QUOTE: begin
                    go_quote = 1'b1;
                end
                ST_ESC: begin
                    run_next = inc_len(run_reg);
                    col_next = inc_pos(col_reg);
                    esc_next = 3'd1;
                    if (is_digit(in_ch)) begin
                        mode_next = ST_ESCDEC;
                    end else if (in_ch == "x") begin
                        mode_next = ST_ESCHEX;
                    end else begin
                        mode_next = ST_QUOTE;
                    end
                    if (in_last) begin
                        bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg, qline_reg, tsc_reg,
                                                          run_next, ERR_UNCLOSED, 1'b1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        halted_next = 1'b1;
                        mode_next = ST_IDLE;
                        dead = 1'b1;
                    end
                end
                ST_ESCDEC, ST_ESCHEX: begin
                    if ((mode_reg == ST_ESCDEC) ? (is_digit(in_ch) && esc_reg < 3'd3)
                                                : (is_hex(in_ch) && esc_reg < 3'd4)) begin
                        run_next = inc_len(run_reg);
                        col_next = inc_pos(col_reg);
                        esc_next = esc_reg + 3'd1;
                        if (in_last) begin
                            bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg, qline_reg,
                                                              tsc_reg, run_next, ERR_UNCLOSED,
                                                              1'b1);
                            bundle.cnt = bundle.cnt + 2'd1;
                            halted_next = 1'b1;
                            mode_next = ST_IDLE;
                            dead = 1'b1;
                        end
                    end else begin
                        mode_next = ST_QUOTE;
                        go_quote = 1'b1;
                    end
                end
                default: begin
                    mode_next = ST_IDLE;
                    go_idle = 1'b1;
                end
            endcase

            // Byte inside quotes.
            if (go_quote) begin
                qc = qs_reg ? 8'h27 : 8'h22;
                run_next = inc_len(run_next);
                if (in_ch == qc) begin
                    bad = qs_reg && (lcc_next != LEN_ONE);
                    bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg,
                                                      bad ? qline_reg : line_next, tsc_reg,
                                                      run_next, bad ? ERR_CHAR_LEN : ERR_NONE,
                                                      1'b0);
                    bundle.cnt = bundle.cnt + 2'd1;
                    col_next = inc_pos(col_next);
                    mode_next = ST_IDLE;
                end else if (in_ch == 8'h0A) begin
                    line_next = inc_pos(line_next);
                    col_next = POS_ONE;
                    if (in_last) begin
                        bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg, qline_reg, tsc_reg,
                                                          run_next, ERR_UNCLOSED, 1'b1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        halted_next = 1'b1;
                        mode_next = ST_IDLE;
                        dead = 1'b1;
                    end
                end else begin
                    lcc_next = inc_len(lcc_next);
                    col_next = inc_pos(col_next);
                    if (in_ch == 8'h5C) begin
                        if (in_last) begin
                            bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg, line_next,
                                                              col_next, run_next, ERR_ESC_END,
                                                              1'b1);
                            bundle.cnt = bundle.cnt + 2'd1;
                            halted_next = 1'b1;
                            mode_next = ST_IDLE;
                            dead = 1'b1;
                        end else begin
                            mode_next = ST_ESC;
                        end
                    end else if (in_last) begin
                        bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_reg, qline_reg, tsc_reg,
                                                          run_next, ERR_UNCLOSED, 1'b1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        halted_next = 1'b1;
                        mode_next = ST_IDLE;
                        dead = 1'b1;
                    end
                end
            end

            // Byte seen with no token open.
            if (go_idle) begin
                k = single_kind(in_ch);
                if (k != KIND_NONE) begin
                    if (!in_last && may_pair(in_ch)) begin
                        pend_next = in_ch;
                        tsc_next = col_next;
                        mode_next = ST_OPPEND;
                    end else begin
                        bundle.tok[bundle.cnt] = make_tok(k, 1'b0, line_next, col_next, LEN_ONE,
                                                          ERR_NONE, 1'b0);
                        bundle.cnt = bundle.cnt + 2'd1;
                        col_next = inc_pos(col_next);
                    end
                end else if (is_letter(in_ch) || is_digit(in_ch)) begin
                    word = is_letter(in_ch);
                    tsc_next = col_next;
                    col_next = inc_pos(col_next);
                    run_next = LEN_ONE;
                    if (word) begin
                        wbuf_next[0] = in_ch;
                    end
                    if (in_last) begin
                        bundle.tok[bundle.cnt] = make_tok(word ? KIND_IDENT : KIND_NUMBER, 1'b0,
                                                          line_next, col_next, LEN_ONE,
                                                          ERR_UNFINISHED, 1'b1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        halted_next = 1'b1;
                        mode_next = ST_IDLE;
                        dead = 1'b1;
                    end else begin
                        mode_next = word ? ST_IDENT : ST_NUMBER;
                    end
                end else if (in_ch == 8'h27 || in_ch == 8'h22) begin
                    tsc_next = col_next;
                    qline_next = line_next;
                    qs_next = (in_ch == 8'h27);
                    run_next = LEN_ONE;
                    lcc_next = '0;
                    col_next = inc_pos(col_next);
                    if (in_last) begin
                        bundle.tok[bundle.cnt] = make_tok(KIND_QUOTED, qs_next, qline_next,
                                                          tsc_next, LEN_ONE, ERR_UNCLOSED, 1'b1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        halted_next = 1'b1;
                        mode_next = ST_IDLE;
                        dead = 1'b1;
                    end else begin
                        mode_next = ST_QUOTE;
                    end
                end else if (in_ch == 8'h5C) begin
                    bundle.tok[bundle.cnt] = make_tok(KIND_NUMBER, 1'b0, line_next, col_next,
                                                      LEN_ONE, ERR_NONE, 1'b0);
                    bundle.cnt = bundle.cnt + 2'd1;
                    col_next = inc_pos(col_next);
                end else if (in_ch == 8'h0A) begin
                    line_next = inc_pos(line_next);
                    col_next = POS_ONE;
                end else if (in_ch == " " || (in_ch >= 8'd9 && in_ch <= 8'd13)) begin
                    col_next = inc_pos(col_next);
                end else begin
                    bundle.tok[bundle.cnt] = make_tok(6'd0, 1'b0, line_next, col_next, LEN_ONE,
                                                      ERR_FAULTY, 1'b0);
                    bundle.cnt = bundle.cnt + 2'd1;
                    col_next = inc_pos(col_next);
                end
            end

            // End of source with no fatal error closes the stream with an EOF token.
            if (!dead && in_last) begin
                bundle.tok[bundle.cnt] = make_tok(KIND_EOF, 1'b0, line_next, col_next, '0,
                                                  ERR_NONE, 1'b1);
                bundle.cnt = bundle.cnt + 2'd1;
                halted_next = 1'b1;
                mode_next = ST_IDLE;
            end
        end
    end

    assign push      = in_fire && (bundle.cnt != 2'd0);
    assign push_data = BUNDLE_W'(bundle);

    // Lexer control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= ST_IDLE;
            pend_reg   <= '0;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            tsc_reg    <= POS_ONE;
            qline_reg  <= POS_ONE;
            run_reg    <= '0;
            lcc_reg    <= '0;
            esc_reg    <= '0;
            qs_reg     <= 1'b0;
            halted_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tsc_reg    <= tsc_next;
            qline_reg  <= qline_next;
            run_reg    <= run_next;
            lcc_reg    <= lcc_next;
            esc_reg    <= esc_next;
            qs_reg     <= qs_next;
            halted_reg <= halted_next;
        end
    end

    // Word buffer holds the leading characters of an identifier.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            wbuf_reg <= wbuf_next;
        end
    end

endmodule

[design/ctok_queue.sv]
// Short queue of token bundles between the front end and the back end.
module ctok_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data,
    output logic [$clog2(ctok_pkg::QUEUE_DEPTH+1)-1:0] level
);
    import ctok_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_reg];
    assign level     = count_reg;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

[design/ctok_back.sv]
// Tokenizer back end: takes bundles from the queue and sends one token per cycle while the receiver is ready.
module ctok_back #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 12,
    parameter int BUNDLE_W      = 2,
    parameter int DATA_W        = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  logic [BUNDLE_W-1:0] q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,
    output logic [6:0]          m_tuser,
    output logic                m_tlast
);
    import ctok_pkg::*;

    typedef struct packed {
        logic                     fin;
        logic [2:0]               err;
        logic [LENGTH_BITS-1:0]   len;
        logic [POSITION_BITS-1:0] col;
        logic [POSITION_BITS-1:0] line;
        logic                     isch;
        logic [5:0]               kind;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t [2:0] tok;
    } bundle_t;

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       have_reg;
    tok_t       tok;
    logic       done;

    assign tok      = cur_reg.tok[idx_reg];
    assign done     = m_tvalid && m_tready && (idx_reg == cur_reg.cnt - 2'd1);
    assign q_pop    = q_valid && (!have_reg || done);
    assign m_tvalid = have_reg;
    assign m_tdata  = DATA_W'({tok.err, tok.len, tok.col, tok.line});
    assign m_tuser  = {tok.isch, tok.kind};
    assign m_tlast  = tok.fin;

    // Current bundle and the position within it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (!have_reg || done) begin
            have_reg <= q_valid;
            idx_reg  <= '0;
        end else if (m_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Bundle payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= bundle_t'(q_data);
        end
    end

endmodule

[tb/sv/c_like_source_tokenizer_tb.sv]
// Self-checking testbench for the C-like source tokenizer.
module c_like_source_tokenizer_tb;
    import ctok_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  RESET_CYCLES = 7;
    localparam int  RANDOM_BYTES = 280;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 20;

    // Lexer modes of the predictor.
    typedef enum logic [2:0] {
        LX_IDLE, LX_OPPEND, LX_IDENT, LX_NUMBER, LX_QUOTE, LX_ESC, LX_ESCDEC, LX_ESCHEX
    } lex_mode_t;

    // One token as the block reports it.
    typedef struct packed {
        logic [5:0]  kind;
        logic        is_char;
        logic [15:0] line;
        logic [15:0] col;
        logic [11:0] len;
        logic [2:0]  err;
        logic        fin;
    } token_t;

    localparam string PAIR_FIRST  = "+--!=><<>&|";
    localparam string PAIR_SECOND = "+->====<>&|";
    localparam string SINGLE_OPS  = "(){}[];,%~^.*/+-<>=!&|";
    localparam string LETTERS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string HEX_CHARS = "0123456789abcdefABCDEFgx";
    localparam string OP_CHARS = "+-!=<>&|(){}[];,%~^.*/";
    string keyword_text [11] = '{"byte", "while", "if", "void", "return", "break",
                                 "continue", "typedef", "struct", "do", "else"};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // ch
    logic        s_tlast;   // last
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // start_line, start_column, token_length, error_code, zero fill
    logic [6:0]  m_tuser;   // token_kind, is_char_literal
    logic        m_tlast;   // last_token

    c_like_source_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Source stream and the tokens it should produce.
    logic [7:0] src_byte [$];
    logic       src_last [$];
    token_t     tokens_due [$];

    // Predictor state.
    lex_mode_t   lx_mode;
    logic [7:0]  held_op;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_col;
    logic [15:0] quote_line;
    logic [11:0] run_len;
    logic [7:0]  word_buf [8];
    logic [11:0] content_cnt;
    logic [2:0]  esc_digits;
    logic        single_quote;
    logic        stopped;

    int sent_idx;
    int accepted;
    int tokens_seen;
    int mismatches;
    int cycles;

    function automatic logic [15:0] pos_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [11:0] len_inc(input logic [11:0] v);
        return (v == 12'hFFF) ? v : v + 12'd1;
    endfunction

    function automatic bit letter(input logic [7:0] c);
        return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_digit(input logic [7:0] c);
        return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic int pair_code(input logic [7:0] a, input logic [7:0] b);
        for (int k = 0; k < 11; k++)
            if (PAIR_FIRST[k] == a && PAIR_SECOND[k] == b) return k;
        return -1;
    endfunction

    function automatic int single_code(input logic [7:0] c);
        for (int k = 0; k < 22; k++)
            if (SINGLE_OPS[k] == c) return 11 + k;
        return -1;
    endfunction

    function automatic bit opens_pair(input logic [7:0] c);
        for (int k = 0; k < 11; k++)
            if (PAIR_FIRST[k] == c) return 1;
        return 0;
    endfunction

    // Keyword kind of the buffered word, or the identifier kind.
    function automatic logic [5:0] word_kind();
        bit same;
        for (int k = 0; k < 11; k++) begin
            if (run_len != keyword_text[k].len() || keyword_text[k].len() > 8) continue;
            same = 1;
            for (int j = 0; j < keyword_text[k].len(); j++)
                if (word_buf[j] != keyword_text[k][j]) same = 0;
            if (same) return KIND_KEYWORD0 + 6'(k);
        end
        return KIND_IDENT;
    endfunction

    function automatic void add_token(input logic [5:0] kind, input logic is_char,
                                      input logic [15:0] line, input logic [15:0] col,
                                      input logic [11:0] len, input logic [2:0] err,
                                      input logic fin);
        tokens_due.push_back('{kind, is_char, line, col, len, err, fin});
    endfunction

    function automatic void fatal_token(input logic [5:0] kind, input logic is_char,
                                        input logic [15:0] line, input logic [15:0] col,
                                        input logic [11:0] len, input logic [2:0] err);
        add_token(kind, is_char, line, col, len, err, 1'b1);
        stopped = 1;
        lx_mode = LX_IDLE;
    endfunction

    // A byte seen while no token is open; returns 1 when it ends the stream.
    function automatic bit idle_byte(input logic [7:0] c, input bit last);
        int k;
        bit word;
        k = single_code(c);
        if (k >= 0) begin
            if (!last && opens_pair(c)) begin
                held_op = c;
                tok_col = cur_col;
                lx_mode = LX_OPPEND;
            end else begin
                add_token(6'(k), 0, cur_line, cur_col, 1, ERR_NONE, 0);
                cur_col = pos_inc(cur_col);
            end
            return 0;
        end
        if (letter(c) || digit(c)) begin
            word = letter(c);
            tok_col = cur_col;
            cur_col = pos_inc(cur_col);
            run_len = 1;
            if (word) word_buf[0] = c;
            if (last) begin
                fatal_token(word ? KIND_IDENT : KIND_NUMBER, 0, cur_line, cur_col, 1,
                            ERR_UNFINISHED);
                return 1;
            end
            lx_mode = word ? LX_IDENT : LX_NUMBER;
            return 0;
        end
        if (c == "'" || c == "\"") begin
            tok_col = cur_col;
            quote_line = cur_line;
            single_quote = (c == "'");
            run_len = 1;
            content_cnt = 0;
            cur_col = pos_inc(cur_col);
            if (last) begin
                fatal_token(KIND_QUOTED, single_quote, quote_line, tok_col, 1, ERR_UNCLOSED);
                return 1;
            end
            lx_mode = LX_QUOTE;
            return 0;
        end
        if (c == "\\") begin
            add_token(KIND_NUMBER, 0, cur_line, cur_col, 1, ERR_NONE, 0);
            cur_col = pos_inc(cur_col);
            return 0;
        end
        if (c == 8'd10) begin
            cur_line = pos_inc(cur_line);
            cur_col = 1;
            return 0;
        end
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            cur_col = pos_inc(cur_col);
            return 0;
        end
        add_token(6'd0, 0, cur_line, cur_col, 1, ERR_FAULTY, 0);
        cur_col = pos_inc(cur_col);
        return 0;
    endfunction

    // End of source while still inside quotes.
    function automatic bit quote_cut(input bit last);
        if (!last) return 0;
        fatal_token(KIND_QUOTED, single_quote, quote_line, tok_col, run_len, ERR_UNCLOSED);
        return 1;
    endfunction

    function automatic bit quote_byte(input logic [7:0] c, input bit last);
        logic [7:0] closing;
        bit bad;
        closing = single_quote ? "'" : "\"";
        run_len = len_inc(run_len);
        if (c == closing) begin
            bad = single_quote && content_cnt != 1;
            add_token(KIND_QUOTED, single_quote, bad ? quote_line : cur_line, tok_col,
                      run_len, bad ? ERR_CHAR_LEN : ERR_NONE, 0);
            cur_col = pos_inc(cur_col);
            lx_mode = LX_IDLE;
            return 0;
        end
        if (c == 8'd10) begin
            cur_line = pos_inc(cur_line);
            cur_col = 1;
        end else begin
            content_cnt = len_inc(content_cnt);
            cur_col = pos_inc(cur_col);
            if (c == "\\") begin
                if (last) begin
                    fatal_token(KIND_QUOTED, single_quote, cur_line, cur_col, run_len,
                                ERR_ESC_END);
                    return 1;
                end
                lx_mode = LX_ESC;
                return 0;
            end
        end
        return quote_cut(last);
    endfunction

    // Advance the predictor by one source byte and queue the tokens it completes.
    function automatic void lex_byte(input logic [7:0] c, input bit last);
        bit dead;
        bit word;
        bit dec;
        int k;
        dead = 0;
        if (stopped) return;
        case (lx_mode)
            LX_OPPEND: begin
                lx_mode = LX_IDLE;
                k = pair_code(held_op, c);
                if (k >= 0) begin
                    add_token(6'(k), 0, cur_line, tok_col, 2, ERR_NONE, 0);
                    cur_col = pos_inc(pos_inc(cur_col));
                end else begin
                    k = single_code(held_op);
                    add_token(6'(k), 0, cur_line, tok_col, 1, ERR_NONE, 0);
                    cur_col = pos_inc(cur_col);
                    dead = idle_byte(c, last);
                end
            end
            LX_IDENT, LX_NUMBER: begin
                word = (lx_mode == LX_IDENT);
                if (word ? letter(c) : digit(c)) begin
                    if (word && run_len < 8) word_buf[run_len[2:0]] = c;
                    run_len = len_inc(run_len);
                    cur_col = pos_inc(cur_col);
                    if (last) begin
                        fatal_token(word ? KIND_IDENT : KIND_NUMBER, 0, cur_line, cur_col,
                                    run_len, ERR_UNFINISHED);
                        dead = 1;
                    end
                end else begin
                    add_token(word ? word_kind() : KIND_NUMBER, 0, cur_line, tok_col,
                              run_len, ERR_NONE, 0);
                    lx_mode = LX_IDLE;
                    dead = idle_byte(c, last);
                end
            end
            LX_QUOTE: dead = quote_byte(c, last);
            LX_ESC: begin
                run_len = len_inc(run_len);
                cur_col = pos_inc(cur_col);
                esc_digits = 1;
                if (digit(c)) lx_mode = LX_ESCDEC;
                else if (c == "x") lx_mode = LX_ESCHEX;
                else lx_mode = LX_QUOTE;
                dead = quote_cut(last);
            end
            LX_ESCDEC, LX_ESCHEX: begin
                dec = (lx_mode == LX_ESCDEC);
                if (dec ? (digit(c) && esc_digits < 3) : (hex_digit(c) && esc_digits < 4)) begin
                    run_len = len_inc(run_len);
                    cur_col = pos_inc(cur_col);
                    esc_digits = esc_digits + 1;
                    dead = quote_cut(last);
                end else begin
                    lx_mode = LX_QUOTE;
                    dead = quote_byte(c, last);
                end
            end
            default: begin
                lx_mode = LX_IDLE;
                dead = idle_byte(c, last);
            end
        endcase
        if (!dead && last) begin
            add_token(KIND_EOF, 0, cur_line, cur_col, 0, ERR_NONE, 1);
            stopped = 1;
            lx_mode = LX_IDLE;
        end
    endfunction

    function automatic void put_byte(input logic [7:0] c, input bit last);
        src_byte.push_back(c);
        src_last.push_back(last);
        lex_byte(c, last);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 0);
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // Content of a quoted literal: plain bytes, escapes and line breaks.
    function automatic void put_quote_body(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0, 1: put_byte(pick(LETTERS), 0);
                2: begin
                    put_byte("\\", 0);
                    case ($urandom_range(4))
                        0: repeat ($urandom_range(1, 4)) put_byte(pick("0123456789"), 0);
                        1: begin
                            put_byte("x", 0);
                            repeat ($urandom_range(0, 4)) put_byte(pick(HEX_CHARS), 0);
                        end
                        2: put_byte(pick("'\""), 0);
                        3: put_byte(8'd10, 0);
                        default: put_byte(pick("nt\\a"), 0);
                    endcase
                end
                3: put_byte(8'd10, 0);
                4: put_byte(pick("'\" +;"), 0);
                default: put_byte(8'($urandom_range(255)), 0);
            endcase
        end
    endfunction

    // One random lexeme, mostly well-formed, sometimes noise.
    function automatic void put_random_lexeme();
        case ($urandom_range(11))
            0, 1: repeat ($urandom_range(1, 2)) put_byte(pick(OP_CHARS), 0);
            2: put_text(keyword_text[$urandom_range(10)]);
            3: repeat ($urandom_range(1, 11)) put_byte(pick(LETTERS), 0);
            4: repeat ($urandom_range(1, 5)) put_byte(pick("0123456789"), 0);
            5: begin
                put_byte("\"", 0);
                put_quote_body($urandom_range(0, 5));
                if ($urandom_range(9) != 0) put_byte("\"", 0);
            end
            6: begin
                put_byte("'", 0);
                put_quote_body($urandom_range(0, 2));
                put_byte("'", 0);
            end
            7: put_byte(pick(" \t\n\v\f\r"), 0);
            8: put_byte("\\", 0);
            9: put_byte(8'($urandom_range(255)), 0);
            default: put_byte(" ", 0);
        endcase
    endfunction

    // Clock.
    initial aclk = 0;
    always #HALF_PERIOD aclk = ~aclk;

    // Idle rate of each side for the current phase of the run.
    function automatic bit sender_rests();
        int ph;
        ph = (accepted * 4) / (src_byte.size() + 1);
        if (ph == 1) return $urandom_range(99) < 83;
        if (ph == 3) return $urandom_range(99) < 34;
        return 0;
    endfunction

    function automatic bit receiver_stalls();
        int ph;
        ph = (accepted * 4) / (src_byte.size() + 1);
        if (ph == 2) return $urandom_range(99) < 83;
        if (ph == 3) return $urandom_range(99) < 34;
        return 0;
    endfunction

    // Source byte driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= 0;
            s_tlast <= 0;
        end else begin
            if (s_tvalid && s_tready) accepted <= accepted + 1;
            if (!s_tvalid || s_tready) begin
                if (sent_idx < src_byte.size() && !sender_rests()) begin
                    s_tvalid <= 1;
                    s_tdata <= src_byte[sent_idx];
                    s_tlast <= src_last[sent_idx];
                    sent_idx <= sent_idx + 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Token monitor and checker.
    always @(posedge aclk) begin
        token_t got;
        token_t want;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= !receiver_stalls();
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[5:0], m_tuser[6], m_tdata[15:0], m_tdata[31:16],
                        m_tdata[43:32], m_tdata[46:44], m_tlast};
                tokens_seen <= tokens_seen + 1;
                if (tokens_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected token kind=%0d line=%0d col=%0d len=%0d err=%0d",
                                 got.kind, got.line, got.col, got.len, got.err);
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"Token mismatch: expected kind=%0d chr=%0d line=%0d ",
                                      "col=%0d len=%0d err=%0d fin=%0d, got kind=%0d ",
                                      "chr=%0d line=%0d col=%0d len=%0d err=%0d fin=%0d"},
                                     want.kind, want.is_char, want.line, want.col, want.len,
                                     want.err, want.fin, got.kind, got.is_char, got.line,
                                     got.col, got.len, got.err, got.fin);
                    end
                end
            end
        end
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        sent_idx = 0;
        accepted = 0;
        tokens_seen = 0;
        mismatches = 0;
        cycles = 0;

        lx_mode = LX_IDLE;
        held_op = 0;
        cur_line = 1;
        cur_col = 1;
        tok_col = 1;
        quote_line = 1;
        run_len = 0;
        content_cnt = 0;
        esc_digits = 0;
        single_quote = 0;
        stopped = 0;

        // Directed part: pairs and a split pair, keyword, escapes, bad char length,
        // lone backslash, faulty bytes.
        put_text("byte x+=a->b!=0;\n");
        put_text("'\\x41''ab'\"\\\"\\12\"\\");
        put_byte(8'h80, 0);
        put_byte(8'hFF, 0);
        put_byte(8'h00, 0);

        // Random lexemes until the byte budget is used.
        while (src_byte.size() < RANDOM_BYTES) put_random_lexeme();
        // The final byte lands in whatever state the stream left open.
        put_byte(pick("a7\"\\; x+"), 1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1;

        while (accepted < src_byte.size() || tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d source bytes through four idle phases; %0d tokens checked.",
                 src_byte.size(), tokens_seen);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d tokens still due", mismatches, tokens_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
